/* sv/lrs_pkg.sv */
// lrs_pkg: shared types, constants and helpers for the lru replacement stack
// no dependencies; imported by the controller, datapath and top level

package lrs_pkg;

  // fixed field widths of the item and result ports
  localparam int KeyW   = 4;
  localparam int RankW  = 3;
  localparam int OccW   = 4;
  localparam int CapW   = 4;

  // defaults and fixed constants
  localparam int MaxEntriesDef = 8;
  localparam int KeyCount      = 16;
  localparam logic [CapW-1:0] CapReset = CapW'(4);

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } lrs_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_key;
    logic update;
  } lrs_cmd_t;

  // wrap a key into the key space by repeated subtraction (narrow value)
  function automatic logic [KeyW-1:0] wrap_key(input logic [KeyW-1:0] v);
    logic [KeyW-1:0] r;
    r = v;
    for (int s = 0; s < 8; s++) begin
      if (KeyCount < (1 << KeyW)) begin
        if (int'(r) >= KeyCount) begin
          r = r - KeyW'(KeyCount);
        end
      end
    end
    return r;
  endfunction

endpackage

/* sv/lrs_ctrl.sv */
// lrs_ctrl: sequencing state machine and result valid flag
// depends on lrs_pkg for the state enum and command struct

module lrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrs_pkg::lrs_cmd_t cmd_o
);
  import lrs_pkg::*;

  lrs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // state and result flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // result register free or emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/lrs_datapath.sv */
// lrs_datapath: recency stack, fill count, capacity register and result registers
// depends on lrs_pkg for widths, the command struct and key wrapping

module lrs_datapath #(
  parameter int MaxEntries = lrs_pkg::MaxEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lrs_pkg::lrs_cmd_t         cmd_i,
  input  logic                      cfg_we_i,
  input  logic [lrs_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic [lrs_pkg::KeyW-1:0]  page_key_i,
  output logic                      hit_o,
  output logic [lrs_pkg::RankW-1:0] hit_rank_o,
  output logic                      evicted_o,
  output logic [lrs_pkg::KeyW-1:0]  evicted_key_o,
  output logic [lrs_pkg::OccW-1:0]  occupancy_o
);
  import lrs_pkg::*;

  localparam int IdxW    = $clog2(MaxEntries);
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int CapExtW = (CntW > CapW) ? CntW : CapW;

  logic [KeyW-1:0]    stack_q [MaxEntries];
  logic [KeyW-1:0]    stack_d [MaxEntries];
  logic [CntW-1:0]    fill_q, fill_d;
  logic [CapW-1:0]    cap_q;
  logic [KeyW-1:0]    key_q;

  logic               hit_q, ev_q;
  logic [RankW-1:0]   rank_q;
  logic [KeyW-1:0]    ev_key_q;
  logic [OccW-1:0]    occ_q;

  logic [CapExtW-1:0] cap_ext, eff_cap, fill_ext;
  logic [MaxEntries-1:0] match;
  logic               found, full, evict;
  logic [IdxW-1:0]    pos, tail_idx;
  logic [CntW-1:0]    tail_full, shift_lim;

  // effective capacity: zero reads as one, saturate at the stack depth
  always_comb begin
    cap_ext  = CapExtW'(cap_q);
    eff_cap  = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CapExtW'(1);
    end else if (cap_ext > CapExtW'(MaxEntries)) begin
      eff_cap = CapExtW'(MaxEntries);
    end
    fill_ext = CapExtW'(fill_q);
    full     = fill_ext >= eff_cap;
  end

  // parallel compare against every held entry
  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = (CntW'(i) < fill_q) && (stack_q[i] == key_q);
    end
  end

  // first matching position, most recent wins
  always_comb begin
    pos = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IdxW'(i);
      end
    end
    found = |match;
  end

  // eviction, shift limit and new fill
  always_comb begin
    evict     = !found && full;
    tail_full = fill_q - CntW'(1);
    tail_idx  = tail_full[IdxW-1:0];
    if (found) begin
      shift_lim = CntW'(pos);
    end else if (evict) begin
      shift_lim = tail_full;
    end else begin
      shift_lim = fill_q;
    end
    fill_d = (found || evict) ? fill_q : fill_q + CntW'(1);
  end

  // new stack contents: key at the top, shift down one place up to the limit
  always_comb begin
    stack_d[0] = key_q;
    for (int i = 1; i < MaxEntries; i++) begin
      stack_d[i] = (CntW'(i) <= shift_lim) ? stack_q[i-1] : stack_q[i];
    end
  end

  // control registers: capacity and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapReset;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        fill_q <= fill_d;
      end
    end
  end

  // key, stack and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= wrap_key(page_key_i);
    end
    if (cmd_i.update) begin
      for (int i = 0; i < MaxEntries; i++) begin
        stack_q[i] <= stack_d[i];
      end
      hit_q    <= found;
      rank_q   <= found ? RankW'(pos) : '0;
      ev_q     <= evict;
      ev_key_q <= evict ? stack_q[tail_idx] : '0;
      occ_q    <= OccW'(fill_d);
    end
  end

  assign hit_o         = hit_q;
  assign hit_rank_o    = rank_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = ev_key_q;
  assign occupancy_o   = occ_q;

  // fill never passes the stack depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxEntries))
    else $error("fill count beyond stack depth");

  // a result is never both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> !(hit_q && ev_q))
    else $error("hit and eviction in one result");

  // a hit leaves the fill count alone
  a_hit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && found) |=> (fill_q == $past(fill_q)))
    else $error("fill changed on a hit");

  // every access leaves at least one key held
  a_occ_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (occ_q != '0))
    else $error("zero occupancy after an access");

endmodule

/* sv/lru_replacement_stack_unit.sv */
// lru_replacement_stack_unit: top level of the lru replacement stack
// depends on lrs_pkg, lrs_ctrl and lrs_datapath
//
//   port group   direction   handshake               payload
//   cfg          in          cfg_we_i (no wait)      cfg_wdata_i
//   in           in          in_valid_i/in_ready_o   page_key_i
//   out          out         out_valid_o/out_ready_i hit, hit_rank, evicted,
//                                                    evicted_key, occupancy
//
// an item first has its key registered in the idle state; then, in the busy
// state, all entries compare in parallel, shift one place and load results.
// the next item is taken while a result still waits; the update waits only
// if the result register is still full and not being taken.
// reset clears the fill count and sets capacity to four; stack entries are
// never read before written, so no clearing pass is needed.

module lru_replacement_stack_unit #(
  parameter int MaxEntries = lrs_pkg::MaxEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lrs_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lrs_pkg::KeyW-1:0]  page_key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [lrs_pkg::RankW-1:0] hit_rank_o,
  output logic                      evicted_o,
  output logic [lrs_pkg::KeyW-1:0]  evicted_key_o,
  output logic [lrs_pkg::OccW-1:0]  occupancy_o
);
  import lrs_pkg::*;

  lrs_cmd_t cmd;

  // sequencing
  lrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // stack and results
  lrs_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .page_key_i    (page_key_i),
    .hit_o         (hit_o),
    .hit_rank_o    (hit_rank_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .occupancy_o   (occupancy_o)
  );

endmodule
